// ----- design/closest_point_on_triangle_macros.svh -----
// Assertion macros for the closest point block.
`ifndef CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH
`define CLOSEST_POINT_ON_TRIANGLE_MACROS_SVH

`ifndef SYNTH
`define CPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define CPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/cpt_pkg.sv -----
`timescale 1ns / 1ps

package cpt_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int WEIGHT_FRAC_DEF = 16;
    localparam int DIST_BITS       = 35;
    // extra fraction bits kept on the offset before squaring
    localparam int OFF_GUARD       = 4;
    localparam int FIFO_DEPTH      = 4;

    typedef enum logic [2:0] {
        REG_A     = 3'd0,
        REG_B     = 3'd1,
        REG_AB    = 3'd2,
        REG_C     = 3'd3,
        REG_AC    = 3'd4,
        REG_BC    = 3'd5,
        REG_FACE  = 3'd6,
        REG_DEGEN = 3'd7
    } region_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// ----- design/cpt_front.sv -----
`timescale 1ns / 1ps

module cpt_front #(
    parameter int CB = cpt_pkg::COORD_BITS_DEF,
    localparam int DW  = CB + 1,
    localparam int PW  = 2 * DW + 2,
    localparam int HW  = PW / 2,
    localparam int LW  = PW - HW,
    localparam int XW  = 2 * PW,
    localparam int VW  = XW + 1,
    localparam int NW  = VW + 2,
    localparam int DDW = PW + 1,
    localparam int PLW = 3 + 9 * DW + 3 * NW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [CB-1:0]  p_in [3],
    input  logic signed [CB-1:0]  a_in [3],
    input  logic signed [CB-1:0]  b_in [3],
    input  logic signed [CB-1:0]  c_in [3],
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PLW-1:0]        out_data
);

    // vector slots: ab, ac, ap, bp, cp, bc
    localparam int VAB = 0;
    localparam int VAC = 1;
    localparam int VAP = 2;
    localparam int VBP = 3;
    localparam int VCP = 4;
    localparam int VBC = 5;
    localparam int OPX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int OPY [6] = '{3, 1, 1, 5, 5, 3};

    logic en;
    logic [5:0] vld_reg;

    logic signed [DW-1:0] vec1_reg [6][3];
    logic signed [DW-1:0] vec2_reg [6][3];
    logic signed [DW-1:0] vec3_reg [6][3];
    logic signed [DW-1:0] vec4_reg [6][3];
    logic signed [DW-1:0] vec5_reg [6][3];
    logic signed [DW-1:0] vec1_next [6][3];

    logic signed [PW-1:0] d2_reg [6];
    logic signed [PW-1:0] d3_reg [6];
    logic signed [PW-1:0] d4_reg [6];
    logic signed [PW-1:0] d5_reg [6];
    logic signed [PW-1:0] d2_next [6];
    logic signed [2*DW-1:0] pr [6][3];

    logic signed [2*LW-1:0]  hh_reg [6];
    logic signed [LW+HW:0]   hl_reg [6];
    logic signed [LW+HW:0]   lh_reg [6];
    logic        [2*HW-1:0]  ll_reg [6];
    logic signed [2*LW-1:0]  hh_next [6];
    logic signed [LW+HW:0]   hl_next [6];
    logic signed [LW+HW:0]   lh_next [6];
    logic        [2*HW-1:0]  ll_next [6];

    logic signed [XW-1:0] prod4_reg [6];
    logic signed [XW-1:0] prod4_next [6];
    logic signed [VW-1:0] v5_reg [3];

    cpt_pkg::region_t     region_reg, region_next;
    logic signed [DW-1:0] e_reg [3], f_reg [3], g_reg [3];
    logic signed [DW-1:0] e_next [3], f_next [3], g_next [3];
    logic signed [NW-1:0] n1_reg, dn_reg, n2_reg;
    logic signed [NW-1:0] n1_next, dn_next, n2_next;

    assign en       = !vld_reg[5] || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vec1_next[VAB][k] = DW'(b_in[k]) - DW'(a_in[k]);
            vec1_next[VAC][k] = DW'(c_in[k]) - DW'(a_in[k]);
            vec1_next[VAP][k] = DW'(p_in[k]) - DW'(a_in[k]);
            vec1_next[VBP][k] = DW'(p_in[k]) - DW'(b_in[k]);
            vec1_next[VCP][k] = DW'(p_in[k]) - DW'(c_in[k]);
            vec1_next[VBC][k] = DW'(c_in[k]) - DW'(b_in[k]);
        end
    end

    // dot products d1..d6
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pr[0][k] = vec1_reg[VAB][k] * vec1_reg[VAP][k];
            pr[1][k] = vec1_reg[VAC][k] * vec1_reg[VAP][k];
            pr[2][k] = vec1_reg[VAB][k] * vec1_reg[VBP][k];
            pr[3][k] = vec1_reg[VAC][k] * vec1_reg[VBP][k];
            pr[4][k] = vec1_reg[VAB][k] * vec1_reg[VCP][k];
            pr[5][k] = vec1_reg[VAC][k] * vec1_reg[VCP][k];
        end
        for (int i = 0; i < 6; i++) begin
            d2_next[i] = PW'(pr[i][0]) + PW'(pr[i][1]) + PW'(pr[i][2]);
        end
    end

    // split the wide area products into half-width partials
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            hh_next[i] = $signed(d2_reg[OPX[i]][PW-1:HW]) *
                         $signed(d2_reg[OPY[i]][PW-1:HW]);
            hl_next[i] = $signed(d2_reg[OPX[i]][PW-1:HW]) *
                         $signed({1'b0, d2_reg[OPY[i]][HW-1:0]});
            lh_next[i] = $signed({1'b0, d2_reg[OPX[i]][HW-1:0]}) *
                         $signed(d2_reg[OPY[i]][PW-1:HW]);
            ll_next[i] = d2_reg[OPX[i]][HW-1:0] * d2_reg[OPY[i]][HW-1:0];
        end
    end

    always_comb begin
        logic signed [XW-1:0] e_hh, e_hl, e_lh, e_ll;
        for (int i = 0; i < 6; i++) begin
            e_hh = XW'(hh_reg[i]);
            e_hl = XW'(hl_reg[i]);
            e_lh = XW'(lh_reg[i]);
            e_ll = XW'(ll_reg[i]);
            prod4_next[i] = (e_hh <<< (2 * HW)) + (e_hl <<< HW) + (e_lh <<< HW) + e_ll;
        end
    end

    // classify the Voronoi region and set up the divides
    always_comb begin
        logic signed [DDW-1:0] d43, d56;
        logic signed [NW-1:0]  den;
        logic vc_np, vb_np, va_np;
        d43   = DDW'(d5_reg[3]) - DDW'(d5_reg[2]);
        d56   = DDW'(d5_reg[4]) - DDW'(d5_reg[5]);
        den   = NW'(v5_reg[0]) + NW'(v5_reg[1]) + NW'(v5_reg[2]);
        vc_np = v5_reg[0][VW-1] || (v5_reg[0] == '0);
        vb_np = v5_reg[1][VW-1] || (v5_reg[1] == '0);
        va_np = v5_reg[2][VW-1] || (v5_reg[2] == '0);

        region_next = cpt_pkg::REG_A;
        for (int k = 0; k < 3; k++) begin
            e_next[k] = vec5_reg[VAP][k];
            f_next[k] = '0;
            g_next[k] = '0;
        end
        n1_next = '0;
        dn_next = '0;
        n2_next = '0;

        if (d5_reg[0] <= 0 && d5_reg[1] <= 0) begin
            region_next = cpt_pkg::REG_A;
        end else if (d5_reg[2] >= 0 && d5_reg[3] <= d5_reg[2]) begin
            region_next = cpt_pkg::REG_B;
            for (int k = 0; k < 3; k++) e_next[k] = vec5_reg[VBP][k];
        end else if (vc_np && d5_reg[0] >= 0 && d5_reg[2] <= 0) begin
            region_next = cpt_pkg::REG_AB;
            for (int k = 0; k < 3; k++) f_next[k] = vec5_reg[VAB][k];
            n1_next = NW'(d5_reg[0]);
            dn_next = NW'(d5_reg[0]) - NW'(d5_reg[2]);
        end else if (d5_reg[5] >= 0 && d5_reg[4] <= d5_reg[5]) begin
            region_next = cpt_pkg::REG_C;
            for (int k = 0; k < 3; k++) e_next[k] = vec5_reg[VCP][k];
        end else if (vb_np && d5_reg[1] >= 0 && d5_reg[5] <= 0) begin
            region_next = cpt_pkg::REG_AC;
            for (int k = 0; k < 3; k++) f_next[k] = vec5_reg[VAC][k];
            n1_next = NW'(d5_reg[1]);
            dn_next = NW'(d5_reg[1]) - NW'(d5_reg[5]);
        end else if (va_np && d43 >= 0 && d56 >= 0) begin
            region_next = cpt_pkg::REG_BC;
            for (int k = 0; k < 3; k++) begin
                e_next[k] = vec5_reg[VBP][k];
                f_next[k] = vec5_reg[VBC][k];
            end
            n1_next = NW'(d43);
            dn_next = NW'(d43) + NW'(d56);
        end else if (den[NW-1] || den == '0) begin
            region_next = cpt_pkg::REG_DEGEN;
        end else begin
            region_next = cpt_pkg::REG_FACE;
            for (int k = 0; k < 3; k++) begin
                f_next[k] = vec5_reg[VAB][k];
                g_next[k] = vec5_reg[VAC][k];
            end
            n1_next = NW'(v5_reg[1]);
            n2_next = NW'(v5_reg[0]);
            dn_next = den;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec1_reg  <= vec1_next;
            vec2_reg  <= vec1_reg;
            vec3_reg  <= vec2_reg;
            vec4_reg  <= vec3_reg;
            vec5_reg  <= vec4_reg;
            d2_reg    <= d2_next;
            d3_reg    <= d2_reg;
            d4_reg    <= d3_reg;
            d5_reg    <= d4_reg;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            lh_reg    <= lh_next;
            ll_reg    <= ll_next;
            prod4_reg <= prod4_next;
            v5_reg[0] <= VW'(prod4_reg[0]) - VW'(prod4_reg[1]);
            v5_reg[1] <= VW'(prod4_reg[2]) - VW'(prod4_reg[3]);
            v5_reg[2] <= VW'(prod4_reg[4]) - VW'(prod4_reg[5]);
            region_reg <= region_next;
            e_reg      <= e_next;
            f_reg      <= f_next;
            g_reg      <= g_next;
            n1_reg     <= n1_next;
            dn_reg     <= dn_next;
            n2_reg     <= n2_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = {region_reg, e_reg[0], e_reg[1], e_reg[2],
                        f_reg[0], f_reg[1], f_reg[2], g_reg[0], g_reg[1], g_reg[2],
                        n1_reg, dn_reg, n2_reg};

endmodule

// ----- design/cpt_fifo.sv -----
`timescale 1ns / 1ps
`include "closest_point_on_triangle_macros.svh"

module cpt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = cpt_pkg::FIFO_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = AW + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [W-1:0]          wdata,
    input  logic                  pop,
    output logic [W-1:0]          rdata,
    output cpt_pkg::fifo_stat_t   stat
);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

    `CPT_ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `CPT_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, count_reg != '0)
    `CPT_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push && !pop, count_reg != CW'(DEPTH))
    `CPT_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- design/cpt_div.sv -----
`timescale 1ns / 1ps

module cpt_div #(
    parameter int NW = 75,
    parameter int WF = cpt_pkg::WEIGHT_FRAC_DEF,
    localparam int Q = WF + 1
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [NW-1:0] den,
    output logic [WF:0]          quo
);

    localparam logic [Q-1:0] ONE = Q'(1) << WF;

    logic          zf_reg  [Q+1];
    logic          ff_reg  [Q+1];
    logic [NW-1:0] rem_reg [Q+1];
    logic [NW-1:0] dv_reg  [Q+1];
    logic [Q-1:0]  q_reg   [Q+1];
    logic [WF:0]   quo_reg;
    logic [Q:0]    rnd;

    // one restoring step per stage: quotient of 2^(WF+1)*num/den
    always_ff @(posedge aclk) begin
        logic [NW-1:0] rem2;
        logic          ge;
        if (en) begin
            zf_reg[0]  <= (num <= 0) || (den <= 0);
            ff_reg[0]  <= num >= den;
            rem_reg[0] <= num;
            dv_reg[0]  <= den;
            q_reg[0]   <= '0;
            for (int k = 1; k <= Q; k++) begin
                rem2 = {rem_reg[k-1][NW-2:0], 1'b0};
                ge   = rem2 >= dv_reg[k-1];
                rem_reg[k] <= ge ? rem2 - dv_reg[k-1] : rem2;
                q_reg[k]   <= {q_reg[k-1][Q-2:0], ge};
                zf_reg[k]  <= zf_reg[k-1];
                ff_reg[k]  <= ff_reg[k-1];
                dv_reg[k]  <= dv_reg[k-1];
            end
            if (zf_reg[Q]) begin
                quo_reg <= '0;
            end else if (ff_reg[Q]) begin
                quo_reg <= ONE;
            end else begin
                quo_reg <= rnd[Q-1:0];
            end
        end
    end

    // halve with round up
    assign rnd = ({1'b0, q_reg[Q]} + 1'b1) >> 1;
    assign quo = quo_reg;

endmodule

// ----- design/cpt_back.sv -----
`timescale 1ns / 1ps

module cpt_back #(
    parameter int CB = cpt_pkg::COORD_BITS_DEF,
    parameter int WF = cpt_pkg::WEIGHT_FRAC_DEF,
    localparam int DW   = CB + 1,
    localparam int PW   = 2 * DW + 2,
    localparam int NW   = 2 * PW + 3,
    localparam int SW   = 3 + 9 * DW,
    localparam int PLW  = SW + 3 * NW,
    localparam int QW   = WF + 1,
    localparam int LAT  = WF + 3,
    localparam int MW0  = DW + WF + 2,
    localparam int OW   = DW + WF + 3,
    localparam int OXW  = OW + 1,
    localparam int S1   = WF - cpt_pkg::OFF_GUARD,
    localparam int S2   = 2 * cpt_pkg::OFF_GUARD,
    localparam int RW   = OXW - S1,
    localparam int SQW  = 2 * RW,
    localparam int SUMW = SQW + 2,
    localparam int RDW  = SUMW + 1,
    localparam int DB   = cpt_pkg::DIST_BITS,
    localparam int MXW  = (RDW > DB) ? RDW : DB
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [PLW-1:0]    in_data,
    output logic              in_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DB-1:0]     m_dist_squared,
    output logic [WF:0]       m_weight_a,
    output logic [WF:0]       m_weight_b,
    output logic [WF:0]       m_weight_c,
    output logic              m_inside_face,
    output logic [2:0]        m_region
);

    localparam logic [QW-1:0] ONE = QW'(1) << WF;

    logic en;
    logic [SW-1:0] head_side;
    logic signed [NW-1:0] n1, dn, n2;
    logic [WF:0] t1, t2;

    logic [SW-1:0] side_reg [LAT];
    logic          vld_reg  [LAT];

    logic [2:0]           rg_bits;
    cpt_pkg::region_t     rg;
    logic signed [DW-1:0] e_v [3], f_v [3], g_v [3];
    logic signed [MW0-1:0] fm [3], gm [3];
    logic signed [OW-1:0] o_next [3];
    logic [QW-1:0]        wa_next, wb_next, wc_next;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [OW-1:0] o1_reg [3];
    logic signed [RW-1:0] r2_reg [3];
    logic signed [SQW-1:0] sq3_reg [3];
    logic [QW-1:0]        wa_reg [3], wb_reg [3], wc_reg [3];
    cpt_pkg::region_t     rg_reg [3];

    logic                 m_valid_reg;
    logic [DB-1:0]        m_dist_reg, dist_next;
    logic [QW-1:0]        m_wa_reg, m_wb_reg, m_wc_reg;
    logic [2:0]           m_region_reg;
    logic                 m_inside_reg;

    assign en     = !m_valid_reg || m_ready;
    assign in_pop = en && in_valid;
    assign {head_side, n1, dn, n2} = in_data;

    cpt_div #(.NW(NW), .WF(WF)) u_div_v (
        .aclk (aclk),
        .en   (en),
        .num  (n1),
        .den  (dn),
        .quo  (t1)
    );

    cpt_div #(.NW(NW), .WF(WF)) u_div_w (
        .aclk (aclk),
        .en   (en),
        .num  (n2),
        .den  (dn),
        .quo  (t2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) vld_reg[i] <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++) vld_reg[i] <= vld_reg[i-1];
            v1_reg      <= vld_reg[LAT-1];
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    assign {rg_bits, e_v[0], e_v[1], e_v[2], f_v[0], f_v[1], f_v[2],
            g_v[0], g_v[1], g_v[2]} = side_reg[LAT-1];
    assign rg = cpt_pkg::region_t'(rg_bits);

    // offset from the nearest point to the query point, Q.(WF+frac)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fm[k] = f_v[k] * $signed({1'b0, t1});
            gm[k] = g_v[k] * $signed({1'b0, t2});
            o_next[k] = (OW'(e_v[k]) <<< WF) - OW'(fm[k]) - OW'(gm[k]);
        end
    end

    always_comb begin
        logic [QW:0] wsum;
        wsum    = {1'b0, t1} + {1'b0, t2};
        wa_next = '0;
        wb_next = '0;
        wc_next = '0;
        case (rg)
            cpt_pkg::REG_A, cpt_pkg::REG_DEGEN: begin
                wa_next = ONE;
            end
            cpt_pkg::REG_B: begin
                wb_next = ONE;
            end
            cpt_pkg::REG_C: begin
                wc_next = ONE;
            end
            cpt_pkg::REG_AB: begin
                wa_next = ONE - t1;
                wb_next = t1;
            end
            cpt_pkg::REG_AC: begin
                wa_next = ONE - t1;
                wc_next = t1;
            end
            cpt_pkg::REG_BC: begin
                wb_next = ONE - t1;
                wc_next = t1;
            end
            cpt_pkg::REG_FACE: begin
                // clamp weight_a when the rounded pair overshoots one
                wa_next = (wsum > {1'b0, ONE}) ? '0 : ONE - wsum[QW-1:0];
                wb_next = t1;
                wc_next = t2;
            end
            default: begin
                wa_next = '0;
            end
        endcase
    end

    always_comb begin
        logic [SUMW-1:0] sum;
        logic [RDW-1:0]  rnd;
        logic [MXW-1:0]  rnd_x;
        sum   = SUMW'($unsigned(sq3_reg[0])) + SUMW'($unsigned(sq3_reg[1]))
              + SUMW'($unsigned(sq3_reg[2]));
        rnd   = (RDW'(sum) + (RDW'(1) << (S2 - 1))) >> S2;
        rnd_x = MXW'(rnd);
        if (rnd_x > MXW'({DB{1'b1}})) begin
            dist_next = '1;
        end else begin
            dist_next = rnd_x[DB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [OXW-1:0] rr;
        if (en) begin
            side_reg[0] <= head_side;
            for (int i = 1; i < LAT; i++) side_reg[i] <= side_reg[i-1];

            o1_reg    <= o_next;
            wa_reg[0] <= wa_next;
            wb_reg[0] <= wb_next;
            wc_reg[0] <= wc_next;
            rg_reg[0] <= rg;
            for (int k = 0; k < 3; k++) begin
                rr = (OXW'(o1_reg[k]) + (OXW'(1) <<< (S1 - 1))) >>> S1;
                r2_reg[k]  <= rr[RW-1:0];
                sq3_reg[k] <= r2_reg[k] * r2_reg[k];
            end
            for (int i = 1; i < 3; i++) begin
                wa_reg[i] <= wa_reg[i-1];
                wb_reg[i] <= wb_reg[i-1];
                wc_reg[i] <= wc_reg[i-1];
                rg_reg[i] <= rg_reg[i-1];
            end

            m_dist_reg   <= dist_next;
            m_wa_reg     <= wa_reg[2];
            m_wb_reg     <= wb_reg[2];
            m_wc_reg     <= wc_reg[2];
            m_region_reg <= rg_reg[2];
            m_inside_reg <= (rg_reg[2] == cpt_pkg::REG_FACE);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dist_squared = m_dist_reg;
    assign m_weight_a     = m_wa_reg;
    assign m_weight_b     = m_wb_reg;
    assign m_weight_c     = m_wc_reg;
    assign m_region       = m_region_reg;
    assign m_inside_face  = m_inside_reg;

endmodule

// ----- design/closest_point_on_triangle.sv -----
`timescale 1ns / 1ps

// Closest point on a triangle. Each request carries a query point and three
// corners (signed fixed point, 8 fraction bits at the default width) and
// yields one result: the squared distance to the nearest point of the
// triangle (Q.16, saturating), the three barycentric weights of that point
// in Q1.WEIGHT_FRAC, the region code (corner, edge, face or degenerate) and
// a face interior flag. One request is taken every cycle while the result
// side keeps up. A request passes through the classifying front end, the
// four-entry queue, the pipelined restoring dividers (one quotient bit per
// stage) and the distance stages. A stall on the result side holds the back
// end; the queue lets the front end keep taking requests until it fills.

module closest_point_on_triangle #(
    parameter int COORD_BITS  = cpt_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC = cpt_pkg::WEIGHT_FRAC_DEF,
    localparam int DW  = COORD_BITS + 1,
    localparam int PW  = 2 * DW + 2,
    localparam int NW  = 2 * PW + 3,
    localparam int PLW = 3 + 9 * DW + 3 * NW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic signed [COORD_BITS-1:0]  s_point_z,
    input  logic signed [COORD_BITS-1:0]  s_a_x,
    input  logic signed [COORD_BITS-1:0]  s_a_y,
    input  logic signed [COORD_BITS-1:0]  s_a_z,
    input  logic signed [COORD_BITS-1:0]  s_b_x,
    input  logic signed [COORD_BITS-1:0]  s_b_y,
    input  logic signed [COORD_BITS-1:0]  s_b_z,
    input  logic signed [COORD_BITS-1:0]  s_c_x,
    input  logic signed [COORD_BITS-1:0]  s_c_y,
    input  logic signed [COORD_BITS-1:0]  s_c_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cpt_pkg::DIST_BITS-1:0] m_dist_squared,
    output logic [WEIGHT_FRAC:0]          m_weight_a,
    output logic [WEIGHT_FRAC:0]          m_weight_b,
    output logic [WEIGHT_FRAC:0]          m_weight_c,
    output logic                          m_inside_face,
    output logic [2:0]                    m_region
);

    logic signed [COORD_BITS-1:0] p_arr [3], a_arr [3], b_arr [3], c_arr [3];
    logic                f_valid, push, pop;
    logic [PLW-1:0]      f_data, q_data;
    cpt_pkg::fifo_stat_t q_stat;

    assign p_arr[0] = s_point_x;
    assign p_arr[1] = s_point_y;
    assign p_arr[2] = s_point_z;
    assign a_arr[0] = s_a_x;
    assign a_arr[1] = s_a_y;
    assign a_arr[2] = s_a_z;
    assign b_arr[0] = s_b_x;
    assign b_arr[1] = s_b_y;
    assign b_arr[2] = s_b_z;
    assign c_arr[0] = s_c_x;
    assign c_arr[1] = s_c_y;
    assign c_arr[2] = s_c_z;

    cpt_front #(.CB(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .p_in      (p_arr),
        .a_in      (a_arr),
        .b_in      (b_arr),
        .c_in      (c_arr),
        .out_valid (f_valid),
        .out_ready (!q_stat.full),
        .out_data  (f_data)
    );

    assign push = f_valid && !q_stat.full;

    cpt_fifo #(.W(PLW), .DEPTH(cpt_pkg::FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (f_data),
        .pop     (pop),
        .rdata   (q_data),
        .stat    (q_stat)
    );

    cpt_back #(.CB(COORD_BITS), .WF(WEIGHT_FRAC)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (!q_stat.empty),
        .in_data        (q_data),
        .in_pop         (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dist_squared (m_dist_squared),
        .m_weight_a     (m_weight_a),
        .m_weight_b     (m_weight_b),
        .m_weight_c     (m_weight_c),
        .m_inside_face  (m_inside_face),
        .m_region       (m_region)
    );

endmodule
